// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define RTI_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When ante holds, cons must hold in the cycle after.
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RTI_ASSERT_ALWAYS(lbl, expr)
`define RTI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/rti_pkg.sv -----
`default_nettype none

package rti_pkg;

    localparam int COORD_W    = 16;
    localparam int RAY_ID_W   = 32;
    localparam int VERT_W     = 3 * COORD_W;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = VERT_W;
    localparam int DIST_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int OPA_W      = COORD_W + 1;
    localparam int OPB_W      = 2 * OPA_W + 1;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 56;
    localparam int STEP_W     = 5;
    localparam int MAC_STEPS  = 24;
    localparam int DIV_STEPS  = DIST_W;
    localparam int PT_STEPS   = 4;
    localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN  = -COORD_MAX - 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_ONE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_TWO   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_THREE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(3);

    typedef enum logic [3:0] {
        A_DX, A_DY, A_DZ,
        A_E1X, A_E1Y, A_E1Z,
        A_E2X, A_E2Y, A_E2Z,
        A_SX, A_SY, A_SZ
    } a_sel_t;

    typedef enum logic [3:0] {
        B_E1X, B_E1Y, B_E1Z,
        B_E2X, B_E2Y, B_E2Z,
        B_PX, B_PY, B_PZ,
        B_QX, B_QY, B_QZ
    } b_sel_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_PX, DST_PY, DST_PZ,
        DST_QX, DST_QY, DST_QZ,
        DST_DET, DST_UN, DST_VN, DST_TN
    } dst_t;

    typedef enum logic [1:0] {
        RES_MISS,
        RES_CACHE,
        RES_HIT
    } res_sel_t;

    typedef struct packed {
        a_sel_t a;
        b_sel_t b;
        logic   neg;
        logic   first;
        dst_t   dst;
    } mac_op_t;

    typedef struct packed {
        logic                  capture;
        logic                  mac_en;
        logic [STEP_W-1:0]     step;
        logic                  norm;
        logic                  div_init;
        logic                  div_sat;
        logic                  div_step;
        logic                  pt_mul;
        logic [1:0]            pt_mul_k;
        logic                  pt_fin;
        logic [1:0]            pt_fin_k;
        logic                  load_res;
        res_sel_t              res_sel;
    } cmd_t;

    typedef struct packed {
        logic cache_hit;
        logic reject;
        logic sat;
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic [RAY_ID_W-1:0]       ray_id;
    } ray_t;

    typedef struct packed {
        logic                      hit;
        logic [DIST_W-1:0]         distance;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
    } result_t;

    function automatic logic signed [COORD_W-1:0] coord_of(
        input logic [VERT_W-1:0] v,
        input logic [1:0]        k
    );
        return v[k*COORD_W +: COORD_W];
    endfunction

    // Multiply-accumulate schedule: edge cross products, then the four dot products.
    function automatic mac_op_t mac_op(input logic [STEP_W-1:0] step);
        mac_op_t m;
        m = '{A_DX, B_E1X, 1'b0, 1'b1, DST_NONE};
        unique case (step)
            5'd0:    m = '{A_DY,  B_E2Z, 1'b0, 1'b1, DST_NONE};
            5'd1:    m = '{A_DZ,  B_E2Y, 1'b1, 1'b0, DST_PX};
            5'd2:    m = '{A_DZ,  B_E2X, 1'b0, 1'b1, DST_NONE};
            5'd3:    m = '{A_DX,  B_E2Z, 1'b1, 1'b0, DST_PY};
            5'd4:    m = '{A_DX,  B_E2Y, 1'b0, 1'b1, DST_NONE};
            5'd5:    m = '{A_DY,  B_E2X, 1'b1, 1'b0, DST_PZ};
            5'd6:    m = '{A_SY,  B_E1Z, 1'b0, 1'b1, DST_NONE};
            5'd7:    m = '{A_SZ,  B_E1Y, 1'b1, 1'b0, DST_QX};
            5'd8:    m = '{A_SZ,  B_E1X, 1'b0, 1'b1, DST_NONE};
            5'd9:    m = '{A_SX,  B_E1Z, 1'b1, 1'b0, DST_QY};
            5'd10:   m = '{A_SX,  B_E1Y, 1'b0, 1'b1, DST_NONE};
            5'd11:   m = '{A_SY,  B_E1X, 1'b1, 1'b0, DST_QZ};
            5'd12:   m = '{A_E1X, B_PX,  1'b0, 1'b1, DST_NONE};
            5'd13:   m = '{A_E1Y, B_PY,  1'b0, 1'b0, DST_NONE};
            5'd14:   m = '{A_E1Z, B_PZ,  1'b0, 1'b0, DST_DET};
            5'd15:   m = '{A_SX,  B_PX,  1'b0, 1'b1, DST_NONE};
            5'd16:   m = '{A_SY,  B_PY,  1'b0, 1'b0, DST_NONE};
            5'd17:   m = '{A_SZ,  B_PZ,  1'b0, 1'b0, DST_UN};
            5'd18:   m = '{A_DX,  B_QX,  1'b0, 1'b1, DST_NONE};
            5'd19:   m = '{A_DY,  B_QY,  1'b0, 1'b0, DST_NONE};
            5'd20:   m = '{A_DZ,  B_QZ,  1'b0, 1'b0, DST_VN};
            5'd21:   m = '{A_E2X, B_QX,  1'b0, 1'b1, DST_NONE};
            5'd22:   m = '{A_E2Y, B_QY,  1'b0, 1'b0, DST_NONE};
            5'd23:   m = '{A_E2Z, B_QZ,  1'b0, 1'b0, DST_TN};
            default: m = '{A_DX,  B_E1X, 1'b0, 1'b1, DST_NONE};
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rti_if.sv -----
`default_nettype none

interface rti_ray_if;
    logic                               valid;
    logic                               ready;
    logic signed [rti_pkg::COORD_W-1:0] origin_x;
    logic signed [rti_pkg::COORD_W-1:0] origin_y;
    logic signed [rti_pkg::COORD_W-1:0] origin_z;
    logic signed [rti_pkg::COORD_W-1:0] dir_x;
    logic signed [rti_pkg::COORD_W-1:0] dir_y;
    logic signed [rti_pkg::COORD_W-1:0] dir_z;
    logic [rti_pkg::RAY_ID_W-1:0]       ray_id;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    ray_id, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  ray_id, output ready);
endinterface

interface rti_result_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [rti_pkg::DIST_W-1:0]         distance;
    logic signed [rti_pkg::COORD_W-1:0] hit_x;
    logic signed [rti_pkg::COORD_W-1:0] hit_y;
    logic signed [rti_pkg::COORD_W-1:0] hit_z;

    modport source (output valid, hit, distance, hit_x, hit_y, hit_z, input ready);
    modport sink (input valid, hit, distance, hit_x, hit_y, hit_z, output ready);
endinterface

interface rti_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rti_pkg::CFG_IDX_W-1:0]   index;
    logic [rti_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ray_triangle_intersection_core.sv -----
// Moller-Trumbore ray/triangle test in signed Q8.8 fixed point. Each ray beat on
// the ray channel yields exactly one result beat: hit, distance t as unsigned
// Q16.16 (saturating, 0 on a miss) and the saturated Q8.8 hit point. The triangle
// and the parallel threshold are written over the cfg channel, which is always
// ready; writing a vertex empties the one-entry cache that replays the last hit
// for a repeated ray id. One ray is in flight at a time. A cached ray is answered
// from the cache; a computed ray is checked first, and when t saturates the
// divider is skipped. The next ray is accepted in the cycle after the result is
// loaded. The work is done by the single shared 17x35 multiply-accumulate unit,
// which forms the cross and dot products in 24 steps, and by the radix-2 divider,
// which produces one bit of t per cycle, 32 bits in all.
// A finished result sits in an output register, so the next ray is accepted
// while it waits to be taken; that ray's result is held back until the register
// has been read.
`default_nettype none
`include "assert_macros.svh"

module ray_triangle_intersection_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rti_ray_if.sink      ray,
    rti_result_if.source result,
    rti_cfg_if.sink      cfg
);

    rti_pkg::cmd_t    cmd;
    rti_pkg::status_t status;
    rti_pkg::ray_t    ray_item;
    rti_pkg::result_t res;
    logic             ray_ready;
    logic             out_valid;

    // Configuration writes go straight into registers, so the port never stalls.
    assign cfg.ready = 1'b1;

    assign ray_item = '{ray.origin_x, ray.origin_y, ray.origin_z,
                        ray.dir_x, ray.dir_y, ray.dir_z, ray.ray_id};
    assign ray.ready = ray_ready;

    // The controller steps through cache check, products, checks, division
    // and hit point; the datapath holds all arithmetic and the cache.
    rti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray.valid),
        .ray_ready (ray_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rti_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .ray_item  (ray_item),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .res       (res)
    );

    assign result.valid    = out_valid;
    assign result.hit      = res.hit;
    assign result.distance = res.distance;
    assign result.hit_x    = res.hit_x;
    assign result.hit_y    = res.hit_y;
    assign result.hit_z    = res.hit_z;

    // Only one ray is worked on at a time.
    `RTI_ASSERT_NEXT(a_one_in_flight, ray.valid && ray.ready, !ray.ready)
    // A new result never overwrites one that has not been taken.
    `RTI_ASSERT_ALWAYS(a_no_overwrite, !cmd.load_res || !out_valid || result.ready)
    // Datapath phases never overlap.
    `RTI_ASSERT_ALWAYS(a_phase_excl, $onehot0({cmd.capture, cmd.mac_en, cmd.norm,
        cmd.div_init, cmd.div_sat, cmd.div_step, cmd.load_res}))

endmodule

`default_nettype wire

// ----- rtl/rti_ctrl.sv -----
`default_nettype none

module rti_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             ray_valid,
    output logic                  ray_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire rti_pkg::status_t status,
    output rti_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CACHE,
        ST_MAC,
        ST_NORM,
        ST_CHECK,
        ST_DIV,
        ST_POINT,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [rti_pkg::STEP_W-1:0]     step_reg, step_next;
    rti_pkg::res_sel_t              res_sel_reg, res_sel_next;
    logic                           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        res_sel_next = res_sel_reg;
        ray_ready    = 1'b0;
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.res_sel  = res_sel_reg;
        cmd.pt_mul_k = step_reg[1:0];
        cmd.pt_fin_k = step_reg[1:0] - 2'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                ray_ready = 1'b1;
                if (ray_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CACHE;
                end
            end
            ST_CACHE:
            begin
                if (status.cache_hit)
                begin
                    res_sel_next = rti_pkg::RES_CACHE;
                    state_next   = ST_DONE;
                end
                else
                begin
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                if (step_reg == rti_pkg::STEP_W'(rti_pkg::MAC_STEPS - 1))
                    state_next = ST_NORM;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                step_next = '0;
                priority if (status.reject)
                begin
                    res_sel_next = rti_pkg::RES_MISS;
                    state_next   = ST_DONE;
                end
                else if (status.sat)
                begin
                    cmd.div_sat = 1'b1;
                    state_next  = ST_POINT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == rti_pkg::STEP_W'(rti_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_POINT;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_POINT:
            begin
                cmd.pt_mul = (step_reg != rti_pkg::STEP_W'(rti_pkg::PT_STEPS - 1));
                cmd.pt_fin = (step_reg != '0);
                if (step_reg == rti_pkg::STEP_W'(rti_pkg::PT_STEPS - 1))
                begin
                    res_sel_next = rti_pkg::RES_HIT;
                    state_next   = ST_DONE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_res)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            res_sel_reg   <= rti_pkg::RES_MISS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/rti_datapath.sv -----
`default_nettype none

module rti_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rti_pkg::cmd_t                 cmd,
    output rti_pkg::status_t                   status,
    input  wire rti_pkg::ray_t                 ray_item,
    input  wire logic                          cfg_we,
    input  wire logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rti_pkg::CFG_DATA_W-1:0] cfg_data,
    output rti_pkg::result_t                   res
);

    localparam int PSUM_W = rti_pkg::ACC_W - rti_pkg::FRAC_W + 1;

    // Configuration and cache.
    logic [rti_pkg::VERT_W-1:0]         vert_reg [3];
    logic [rti_pkg::THR_W-1:0]          thr_reg;
    logic                               cache_valid_reg;
    logic [rti_pkg::RAY_ID_W-1:0]       cached_id_reg;
    logic [rti_pkg::DIST_W-1:0]         cached_dist_reg;
    logic signed [rti_pkg::COORD_W-1:0] cached_pt_reg [3];

    // Working registers for one ray.
    logic signed [rti_pkg::COORD_W-1:0] o_reg [3];
    logic signed [rti_pkg::COORD_W-1:0] d_reg [3];
    logic signed [rti_pkg::OPA_W-1:0]   s_reg [3];
    logic [rti_pkg::RAY_ID_W-1:0]       id_reg;
    logic signed [rti_pkg::OPB_W-1:0]   p_reg [3];
    logic signed [rti_pkg::OPB_W-1:0]   q_reg [3];
    logic signed [rti_pkg::ACC_W-1:0]   det_reg, un_reg, vn_reg, tn_reg;
    logic signed [rti_pkg::ACC_W-1:0]   acc_reg;
    logic [rti_pkg::ACC_W-1:0]          rem_reg;
    logic [rti_pkg::DIST_W-1:0]         dl_reg;
    logic [rti_pkg::DIST_W-1:0]         tq_reg;
    logic signed [rti_pkg::COORD_W-1:0] hp_reg [3];
    rti_pkg::result_t                   res_reg;

    logic signed [rti_pkg::OPA_W-1:0]   e1 [3];
    logic signed [rti_pkg::OPA_W-1:0]   e2 [3];
    logic signed [rti_pkg::COORD_W-1:0] o_in [3];
    logic signed [rti_pkg::COORD_W-1:0] d_in [3];
    rti_pkg::mac_op_t                   op;
    logic signed [rti_pkg::OPA_W-1:0]   a_op;
    logic signed [rti_pkg::OPB_W-1:0]   b_op;
    logic signed [rti_pkg::PROD_W-1:0]  prod;
    logic signed [rti_pkg::ACC_W-1:0]   acc_base, acc_next;
    logic [rti_pkg::ACC_W-1:0]          rs;
    logic                               ge;
    logic signed [PSUM_W-1:0]           psum;
    logic signed [rti_pkg::COORD_W-1:0] psat;
    logic signed [rti_pkg::ACC_W:0]     uv_sum;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = rti_pkg::OPA_W'(rti_pkg::coord_of(vert_reg[1], 2'(k)))
                  - rti_pkg::OPA_W'(rti_pkg::coord_of(vert_reg[0], 2'(k)));
            e2[k] = rti_pkg::OPA_W'(rti_pkg::coord_of(vert_reg[2], 2'(k)))
                  - rti_pkg::OPA_W'(rti_pkg::coord_of(vert_reg[0], 2'(k)));
        end
        o_in[0] = ray_item.origin_x;
        o_in[1] = ray_item.origin_y;
        o_in[2] = ray_item.origin_z;
        d_in[0] = ray_item.dir_x;
        d_in[1] = ray_item.dir_y;
        d_in[2] = ray_item.dir_z;
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op = rti_pkg::mac_op(cmd.step);
        unique case (op.a)
            rti_pkg::A_DX:  a_op = rti_pkg::OPA_W'(d_reg[0]);
            rti_pkg::A_DY:  a_op = rti_pkg::OPA_W'(d_reg[1]);
            rti_pkg::A_DZ:  a_op = rti_pkg::OPA_W'(d_reg[2]);
            rti_pkg::A_E1X: a_op = e1[0];
            rti_pkg::A_E1Y: a_op = e1[1];
            rti_pkg::A_E1Z: a_op = e1[2];
            rti_pkg::A_E2X: a_op = e2[0];
            rti_pkg::A_E2Y: a_op = e2[1];
            rti_pkg::A_E2Z: a_op = e2[2];
            rti_pkg::A_SX:  a_op = s_reg[0];
            rti_pkg::A_SY:  a_op = s_reg[1];
            rti_pkg::A_SZ:  a_op = s_reg[2];
            default:        a_op = '0;
        endcase
        unique case (op.b)
            rti_pkg::B_E1X: b_op = rti_pkg::OPB_W'(e1[0]);
            rti_pkg::B_E1Y: b_op = rti_pkg::OPB_W'(e1[1]);
            rti_pkg::B_E1Z: b_op = rti_pkg::OPB_W'(e1[2]);
            rti_pkg::B_E2X: b_op = rti_pkg::OPB_W'(e2[0]);
            rti_pkg::B_E2Y: b_op = rti_pkg::OPB_W'(e2[1]);
            rti_pkg::B_E2Z: b_op = rti_pkg::OPB_W'(e2[2]);
            rti_pkg::B_PX:  b_op = p_reg[0];
            rti_pkg::B_PY:  b_op = p_reg[1];
            rti_pkg::B_PZ:  b_op = p_reg[2];
            rti_pkg::B_QX:  b_op = q_reg[0];
            rti_pkg::B_QY:  b_op = q_reg[1];
            rti_pkg::B_QZ:  b_op = q_reg[2];
            default:        b_op = '0;
        endcase
        if (cmd.pt_mul)
        begin
            a_op = rti_pkg::OPA_W'(d_reg[cmd.pt_mul_k]);
            b_op = $signed({{(rti_pkg::OPB_W - rti_pkg::DIST_W){1'b0}}, tq_reg});
        end
        prod     = a_op * b_op;
        acc_base = (op.first || cmd.pt_mul) ? '0 : acc_reg;
        if (op.neg && !cmd.pt_mul)
            acc_next = acc_base - rti_pkg::ACC_W'(prod);
        else
            acc_next = acc_base + rti_pkg::ACC_W'(prod);
    end

    // Restoring division step, hit point add with saturation, and the status flags.
    always_comb
    begin
        rs = {rem_reg[rti_pkg::ACC_W-2:0], dl_reg[rti_pkg::DIST_W-1]};
        ge = (rs >= $unsigned(det_reg));

        psum = PSUM_W'(o_reg[cmd.pt_fin_k]) + PSUM_W'(acc_reg >>> rti_pkg::FRAC_W);
        if (psum > PSUM_W'(rti_pkg::COORD_MAX))
            psat = rti_pkg::COORD_W'(rti_pkg::COORD_MAX);
        else if (psum < PSUM_W'(rti_pkg::COORD_MIN))
            psat = rti_pkg::COORD_W'(rti_pkg::COORD_MIN);
        else
            psat = psum[rti_pkg::COORD_W-1:0];

        uv_sum = (rti_pkg::ACC_W+1)'(un_reg) + (rti_pkg::ACC_W+1)'(vn_reg);

        status.cache_hit = cache_valid_reg && (id_reg == cached_id_reg);
        status.reject    = (det_reg == '0)
                        || ($unsigned(det_reg) < rti_pkg::ACC_W'(thr_reg))
                        || (un_reg < 0) || (un_reg > det_reg)
                        || (vn_reg < 0) || (uv_sum > (rti_pkg::ACC_W+1)'(det_reg))
                        || (tn_reg < 0);
        status.sat = ({{rti_pkg::FRAC_W{1'b0}}, $unsigned(tn_reg)}
                      >= {$unsigned(det_reg), {rti_pkg::FRAC_W{1'b0}}});
    end

    // Configuration registers and the one-entry cache.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_reg[0]     <= '0;
            vert_reg[1]     <= '0;
            vert_reg[2]     <= '0;
            thr_reg         <= rti_pkg::THR_RESET;
            cache_valid_reg <= 1'b0;
            cached_id_reg   <= '0;
            cached_dist_reg <= '0;
            cached_pt_reg[0] <= '0;
            cached_pt_reg[1] <= '0;
            cached_pt_reg[2] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rti_pkg::CFG_VERTEX_ONE:
                    begin
                        vert_reg[0]     <= cfg_data;
                        cache_valid_reg <= 1'b0;
                    end
                    rti_pkg::CFG_VERTEX_TWO:
                    begin
                        vert_reg[1]     <= cfg_data;
                        cache_valid_reg <= 1'b0;
                    end
                    rti_pkg::CFG_VERTEX_THREE:
                    begin
                        vert_reg[2]     <= cfg_data;
                        cache_valid_reg <= 1'b0;
                    end
                    rti_pkg::CFG_THRESHOLD:
                    begin
                        thr_reg <= cfg_data[rti_pkg::THR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_res && cmd.res_sel == rti_pkg::RES_HIT)
            begin
                cache_valid_reg <= 1'b1;
                cached_id_reg   <= id_reg;
                cached_dist_reg <= tq_reg;
                cached_pt_reg   <= hp_reg;
            end
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg <= ray_item.ray_id;
            for (int k = 0; k < 3; k++)
            begin
                o_reg[k] <= o_in[k];
                d_reg[k] <= d_in[k];
                s_reg[k] <= rti_pkg::OPA_W'(o_in[k])
                          - rti_pkg::OPA_W'(rti_pkg::coord_of(vert_reg[0], 2'(k)));
            end
        end

        if (cmd.mac_en || cmd.pt_mul)
            acc_reg <= acc_next;

        if (cmd.mac_en)
        begin
            unique case (op.dst)
                rti_pkg::DST_PX:  p_reg[0] <= acc_next[rti_pkg::OPB_W-1:0];
                rti_pkg::DST_PY:  p_reg[1] <= acc_next[rti_pkg::OPB_W-1:0];
                rti_pkg::DST_PZ:  p_reg[2] <= acc_next[rti_pkg::OPB_W-1:0];
                rti_pkg::DST_QX:  q_reg[0] <= acc_next[rti_pkg::OPB_W-1:0];
                rti_pkg::DST_QY:  q_reg[1] <= acc_next[rti_pkg::OPB_W-1:0];
                rti_pkg::DST_QZ:  q_reg[2] <= acc_next[rti_pkg::OPB_W-1:0];
                rti_pkg::DST_DET: det_reg  <= acc_next;
                rti_pkg::DST_UN:  un_reg   <= acc_next;
                rti_pkg::DST_VN:  vn_reg   <= acc_next;
                rti_pkg::DST_TN:  tn_reg   <= acc_next;
                default:
                begin
                end
            endcase
        end

        // A negative determinant flips the sign of every term.
        if (cmd.norm && det_reg < 0)
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end

        if (cmd.div_init)
        begin
            rem_reg <= $unsigned(tn_reg) >> rti_pkg::FRAC_W;
            dl_reg  <= {tn_reg[rti_pkg::FRAC_W-1:0],
                        {(rti_pkg::DIST_W - rti_pkg::FRAC_W){1'b0}}};
            tq_reg  <= '0;
        end
        else if (cmd.div_sat)
            tq_reg <= '1;
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? (rs - $unsigned(det_reg)) : rs;
            dl_reg  <= {dl_reg[rti_pkg::DIST_W-2:0], 1'b0};
            tq_reg  <= {tq_reg[rti_pkg::DIST_W-2:0], ge};
        end

        if (cmd.pt_fin)
            hp_reg[cmd.pt_fin_k] <= psat;

        if (cmd.load_res)
        begin
            unique case (cmd.res_sel)
                rti_pkg::RES_CACHE:
                    res_reg <= '{1'b1, cached_dist_reg, cached_pt_reg[0],
                                 cached_pt_reg[1], cached_pt_reg[2]};
                rti_pkg::RES_HIT:
                    res_reg <= '{1'b1, tq_reg, hp_reg[0], hp_reg[1], hp_reg[2]};
                default:
                    res_reg <= '0;
            endcase
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- verif/tb_ray_triangle_intersection_core.sv -----
`timescale 1ns / 100ps

module tb_ray_triangle_intersection_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_RAYS = 1800;

    logic clk;
    logic rst_n;

    rti_ray_if    ray_ch ();
    rti_result_if res_ch ();
    rti_cfg_if    cfg_ch ();

    ray_triangle_intersection_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray    (ray_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // The clock runs with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // This is the testbench's own copy of the triangle registers and of the
    // one-entry repeat cache.
    logic [rti_pkg::VERT_W-1:0]   tri_vert [3];
    logic [rti_pkg::THR_W-1:0]    par_thr;
    logic                         hit_cached;
    logic [rti_pkg::RAY_ID_W-1:0] hit_cached_id;
    logic [rti_pkg::DIST_W-1:0]   hit_cached_dist;
    logic [rti_pkg::VERT_W-1:0]   hit_cached_pt;

    rti_pkg::result_t expected_hits [$];
    int               mismatches;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_stall_pct;

    // Each directed row holds a ray, a flag that tells whether the expected
    // result was typed in, and that expected result.
    typedef struct {
        rti_pkg::ray_t    r;
        logic             fixed;
        rti_pkg::result_t res;
    } ray_row_t;

    function automatic logic signed [63:0] vcoord(input int unsigned v, input int k);
        logic signed [rti_pkg::COORD_W-1:0] c;
        c = tri_vert[v][k*rti_pkg::COORD_W +: rti_pkg::COORD_W];
        return 64'(c);
    endfunction

    function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] x);
        if (x > rti_pkg::COORD_MAX)
            return rti_pkg::COORD_MAX;
        if (x < rti_pkg::COORD_MIN)
            return rti_pkg::COORD_MIN;
        return x;
    endfunction

    // Moller-Trumbore in exact integers, in units of 2^-24. On a hit, the
    // cache is refilled with the new answer.
    function automatic rti_pkg::result_t intersect_ray(input rti_pkg::ray_t r);
        rti_pkg::result_t res;
        logic signed [63:0] o [3];
        logic signed [63:0] d [3];
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] s [3];
        logic signed [63:0] p [3];
        logic signed [63:0] q [3];
        logic signed [63:0] det, un, vn, tn, prod, fl;
        logic [63:0] quo, rem, frac, tq;
        logic [rti_pkg::VERT_W-1:0] packed_pt;
        res = '0;
        if (hit_cached && r.ray_id == hit_cached_id)
        begin
            res.hit = 1'b1;
            res.distance = hit_cached_dist;
            res.hit_x = hit_cached_pt[15:0];
            res.hit_y = hit_cached_pt[31:16];
            res.hit_z = hit_cached_pt[47:32];
            return res;
        end
        o[0] = 64'(r.origin_x); o[1] = 64'(r.origin_y); o[2] = 64'(r.origin_z);
        d[0] = 64'(r.dir_x);    d[1] = 64'(r.dir_y);    d[2] = 64'(r.dir_z);
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = vcoord(1, k) - vcoord(0, k);
            e2[k] = vcoord(2, k) - vcoord(0, k);
            s[k]  = o[k] - vcoord(0, k);
        end
        p[0] = d[1] * e2[2] - d[2] * e2[1];
        p[1] = d[2] * e2[0] - d[0] * e2[2];
        p[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
        vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0)
        begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        if (det == 0 || det < 64'(par_thr))
            return res;
        if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0)
            return res;
        quo = 64'(tn) / 64'(det);
        if (quo > 64'hFFFF)
        begin
            tq = 64'hFFFF_FFFF;
        end
        else
        begin
            rem = 64'(tn) % 64'(det);
            frac = 0;
            for (int k = 0; k < rti_pkg::FRAC_W; k++)
            begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= 64'(det))
                begin
                    rem = rem - 64'(det);
                    frac[0] = 1'b1;
                end
            end
            tq = (quo << 16) | frac;
        end
        res.hit = 1'b1;
        res.distance = tq[31:0];
        for (int k = 0; k < 3; k++)
        begin
            prod = d[k] * $signed(tq);
            // The arithmetic shift floors toward minus infinity.
            fl = prod >>> 16;
            packed_pt[k*rti_pkg::COORD_W +: rti_pkg::COORD_W] =
                rti_pkg::COORD_W'(clamp_coord(o[k] + fl));
        end
        res.hit_x = packed_pt[15:0];
        res.hit_y = packed_pt[31:16];
        res.hit_z = packed_pt[47:32];
        hit_cached = 1'b1;
        hit_cached_id = r.ray_id;
        hit_cached_dist = tq[31:0];
        hit_cached_pt = packed_pt;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // One register write; the channel then idles before the task returns.
    task automatic write_reg(input logic [rti_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rti_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            rti_pkg::CFG_VERTEX_ONE:
            begin
                tri_vert[0] = val; hit_cached = 1'b0;
            end
            rti_pkg::CFG_VERTEX_TWO:
            begin
                tri_vert[1] = val; hit_cached = 1'b0;
            end
            rti_pkg::CFG_VERTEX_THREE:
            begin
                tri_vert[2] = val; hit_cached = 1'b0;
            end
            rti_pkg::CFG_THRESHOLD:
                par_thr = val[rti_pkg::THR_W-1:0];
            default:
                ;
        endcase
        @(posedge clk);
    endtask

    // Offer one ray beat, and hold the valid high until the block takes it.
    // The sender may idle before the beat; the valid stays high after the
    // beat so that the next ray can follow at once.
    task automatic send_ray(input rti_pkg::ray_t r, input logic fixed,
                            input rti_pkg::result_t fixed_res);
        rti_pkg::result_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            ray_ch.valid <= 1'b0;
            @(posedge clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= r.origin_x;
        ray_ch.origin_y <= r.origin_y;
        ray_ch.origin_z <= r.origin_z;
        ray_ch.dir_x    <= r.dir_x;
        ray_ch.dir_y    <= r.dir_y;
        ray_ch.dir_z    <= r.dir_z;
        ray_ch.ray_id   <= r.ray_id;
        do
            @(posedge clk);
        while (!ray_ch.ready);
        pred = intersect_ray(r);
        expected_hits.push_back(fixed ? fixed_res : pred);
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain;
        ray_ch.valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    function automatic logic [rti_pkg::VERT_W-1:0] pack_vert(input int x, input int y,
                                                             input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // Most rays start in a bounded box above z = 0 and point down in z, so that
    // hits are common; some get random directions, and the rest use fully random fields.
    function automatic rti_pkg::ray_t random_ray(input logic [rti_pkg::RAY_ID_W-1:0] id);
        rti_pkg::ray_t r;
        int sel;
        sel = $urandom_range(99);
        r.ray_id = id;
        if (sel < 30)
        begin
            r.origin_x = rti_pkg::COORD_W'($urandom);
            r.origin_y = rti_pkg::COORD_W'($urandom);
            r.origin_z = rti_pkg::COORD_W'($urandom);
            r.dir_x = rti_pkg::COORD_W'($urandom);
            r.dir_y = rti_pkg::COORD_W'($urandom);
            r.dir_z = rti_pkg::COORD_W'($urandom);
        end
        else
        begin
            r.origin_x = rti_pkg::COORD_W'($signed($urandom_range(0, 1024)) - 512);
            r.origin_y = rti_pkg::COORD_W'($signed($urandom_range(0, 1024)) - 512);
            r.origin_z = rti_pkg::COORD_W'($signed($urandom_range(0, 1024)) + 256);
            r.dir_x = rti_pkg::COORD_W'($signed($urandom_range(0, 512)) - 256);
            r.dir_y = rti_pkg::COORD_W'($signed($urandom_range(0, 512)) - 256);
            r.dir_z = rti_pkg::COORD_W'(-$signed($urandom_range(1, 2048)));
            if (sel > 90)
            begin
                r.dir_x = rti_pkg::COORD_W'($urandom);
                r.dir_y = rti_pkg::COORD_W'($urandom);
                r.dir_z = rti_pkg::COORD_W'($urandom);
            end
        end
        return r;
    endfunction

    // Results are taken with random stalls and compared against the oldest
    // expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    rti_pkg::result_t e;
                    e = expected_hits.pop_front();
                    if (res_ch.hit !== e.hit)
                        report_mismatch($sformatf("hit %0b, expected %0b", res_ch.hit, e.hit));
                    if (res_ch.distance !== e.distance)
                        report_mismatch($sformatf("distance %h, expected %h",
                                                  res_ch.distance, e.distance));
                    if (res_ch.hit_x !== e.hit_x)
                        report_mismatch($sformatf("hit_x %h, expected %h", res_ch.hit_x, e.hit_x));
                    if (res_ch.hit_y !== e.hit_y)
                        report_mismatch($sformatf("hit_y %h, expected %h", res_ch.hit_y, e.hit_y));
                    if (res_ch.hit_z !== e.hit_z)
                        report_mismatch($sformatf("hit_z %h, expected %h", res_ch.hit_z, e.hit_z));
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The run is stopped at the cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_ray_triangle_intersection_core failed");
            $finish;
        end
    end

    initial
    begin
        ray_row_t rows [$];
        ray_row_t row;
        rti_pkg::result_t miss;
        logic [rti_pkg::RAY_ID_W-1:0] next_id;
        int phase_send_pct [4];
        int phase_stall_pct [4];

        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        miss = '0;
        tri_vert[0] = '0; tri_vert[1] = '0; tri_vert[2] = '0;
        par_thr = rti_pkg::THR_RESET;
        hit_cached = 1'b0;
        hit_cached_id = '0;
        hit_cached_dist = '0;
        hit_cached_pt = '0;

        rst_n = 1'b0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;    ray_ch.dir_y = '0;    ray_ch.dir_z = '0;
        ray_ch.ray_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the triangle is degenerate, so every ray misses, even
        // ray id 0, which the empty cache must not answer.
        row.fixed = 1'b1;
        row.res = miss;
        row.r = '{16'sh0100, 16'sh0100, 16'sh0100, -16'sh0100, 16'sh0000, 16'sh0000, 32'h0};
        rows.push_back(row);
        row.r = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000,
                  32'hFFFF_FFFF};
        rows.push_back(row);
        foreach (rows[i])
            send_ray(rows[i].r, rows[i].fixed, rows[i].res);
        drain();

        // Triangle in the z = 0 plane: (0,0), (2,0), (0,2) in Q8.8.
        write_reg(rti_pkg::CFG_VERTEX_ONE,   pack_vert(0, 0, 0));
        write_reg(rti_pkg::CFG_VERTEX_TWO,   pack_vert(512, 0, 0));
        write_reg(rti_pkg::CFG_VERTEX_THREE, pack_vert(0, 512, 0));
        rows.delete();
        // A straight hit at t = 1 from z = 1; then a repeat of its id from
        // somewhere else that the cache must answer.
        row.fixed = 1'b1;
        row.res = '{1'b1, 32'h0001_0000, 16'sh0080, 16'sh0080, 16'sh0000};
        row.r = '{16'sh0080, 16'sh0080, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd7};
        rows.push_back(row);
        row.r = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 32'd7};
        rows.push_back(row);
        // A ray parallel to the plane has a zero determinant.
        row.res = miss;
        row.r = '{16'sh0080, 16'sh0080, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, 32'd8};
        rows.push_back(row);
        // Outside u, outside v, outside u+v, and behind the origin.
        row.r = '{-16'sh0080, 16'sh0080, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd9};
        rows.push_back(row);
        row.r = '{16'sh0080, -16'sh0080, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd10};
        rows.push_back(row);
        row.r = '{16'sh0180, 16'sh0180, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd11};
        rows.push_back(row);
        row.r = '{16'sh0080, 16'sh0080, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100, 32'd12};
        rows.push_back(row);
        // A hit from below, with a negative determinant, and edge and corner hits.
        row.fixed = 1'b0;
        row.r = '{16'sh0080, 16'sh0080, -16'sh0200, 16'sh0000, 16'sh0000, 16'sh0100, 32'd13};
        rows.push_back(row);
        row.r = '{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd14};
        rows.push_back(row);
        row.r = '{16'sh0100, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd15};
        rows.push_back(row);
        // A tiny direction gives a large t that still fits, and two rays use long
        // directions.
        row.r = '{16'sh0080, 16'sh0080, 16'sh7FFF, 16'sh0000, 16'sh0000, -16'sh0001, 32'd16};
        rows.push_back(row);
        row.r = '{16'sh0080, 16'sh0080, 16'sh7FFF, 16'sh0000, 16'sh0000, -16'sh8000, 32'd17};
        rows.push_back(row);
        row.r = '{16'sh0010, 16'sh0010, 16'sh0001, 16'sh7FFF, -16'sh8000, -16'sh0001, 32'd18};
        rows.push_back(row);
        foreach (rows[i])
            send_ray(rows[i].r, rows[i].fixed, rows[i].res);
        drain();

        // With this triangle every nonzero determinant is at least 2^18, so
        // even the largest threshold passes the steep hit, and at zero only a
        // zero determinant misses. Neither write empties the cache.
        write_reg(rti_pkg::CFG_THRESHOLD, '1);
        row.r = '{16'sh0080, 16'sh0080, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0100, 32'd20};
        send_ray(row.r, 1'b0, miss);
        send_ray(row.r, 1'b0, miss);
        row.r.ray_id = 32'd18;
        send_ray(row.r, 1'b0, miss);
        drain();
        write_reg(rti_pkg::CFG_THRESHOLD, '0);
        row.r = '{16'sh0080, 16'sh0080, 16'sh0100, 16'sh0001, 16'sh0000, 16'sh0000, 32'd21};
        send_ray(row.r, 1'b1, miss);
        row.r = '{16'sh0080, 16'sh0080, 16'sh0100, 16'sh0000, 16'sh0000, -16'sh0001, 32'd22};
        send_ray(row.r, 1'b0, miss);
        drain();

        // Random phases, each with its own triangle and threshold, cycling through
        // four idling patterns.
        phase_send_pct  = '{0, 45, 0, 32};
        phase_stall_pct = '{0, 0, 45, 32};
        next_id = $urandom;
        for (int ph = 0; ph < 8; ph++)
        begin
            int reg_pick;
            if (ph % 4 == 3)
            begin
                write_reg(rti_pkg::CFG_VERTEX_ONE,
                          rti_pkg::CFG_DATA_W'({$urandom, $urandom}));
                write_reg(rti_pkg::CFG_VERTEX_TWO,
                          rti_pkg::CFG_DATA_W'({$urandom, $urandom}));
                write_reg(rti_pkg::CFG_VERTEX_THREE,
                          rti_pkg::CFG_DATA_W'({$urandom, $urandom}));
            end
            else
            begin
                write_reg(rti_pkg::CFG_VERTEX_ONE, pack_vert($urandom_range(0, 1024) - 512,
                          $urandom_range(0, 1024) - 512, $urandom_range(0, 256) - 128));
                write_reg(rti_pkg::CFG_VERTEX_TWO, pack_vert($urandom_range(0, 1024) - 512,
                          $urandom_range(0, 1024) - 512, $urandom_range(0, 256) - 128));
                write_reg(rti_pkg::CFG_VERTEX_THREE, pack_vert($urandom_range(0, 1024) - 512,
                          $urandom_range(0, 1024) - 512, $urandom_range(0, 256) - 128));
            end
            reg_pick = $urandom_range(3);
            write_reg(rti_pkg::CFG_THRESHOLD,
                      rti_pkg::CFG_DATA_W'(reg_pick == 0 ? 16'h0 : reg_pick == 1 ? 16'hFFFF :
                                           16'($urandom_range(0, 4096))));
            send_idle_pct  = phase_send_pct[ph % 4];
            recv_stall_pct = phase_stall_pct[ph % 4];
            for (int n = 0; n < RANDOM_RAYS / 8; n++)
            begin
                rti_pkg::ray_t r;
                // Ids repeat often, so the cache is exercised.
                if ($urandom_range(99) < 25)
                    r = random_ray(hit_cached && $urandom_range(1) ? hit_cached_id : next_id);
                else
                    r = random_ray(++next_id);
                send_ray(r, 1'b0, miss);
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb_ray_triangle_intersection_core passed");
        else
            $display("tb_ray_triangle_intersection_core failed");
        $finish;
    end

endmodule
